// File: src/mep_pkg.sv
package mep_pkg;

    localparam int EDGE_W  = 32;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 24;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W   = 48;
    localparam int COLOR_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

    localparam logic [EDGE_W-1:0]  RST_LEFT  = 32'hE000_0000;
    localparam logic [EDGE_W-1:0]  RST_TOP   = 32'h2000_0000;
    localparam logic [STEP_W-1:0]  RST_STEP  = 31'd262144;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 24'd4096;

    typedef struct packed {
        logic               start;
        logic [LIMIT_W-1:0] limit;
    } mep_ctl_t;

    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] count;
    } mep_status_t;

endpackage

// File: src/mep_iter.sv
module mep_iter
    import mep_pkg::*;
#(
    parameter int FRAC_BITS   = 28,
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mep_ctl_t                      ctl,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output mep_status_t                   status
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * CW;
    localparam int SW0 = (2 * FRAC_BITS + 3 > PW + 1) ? 2 * FRAC_BITS + 3 : PW + 1;
    localparam int SW  = (FRAC_BITS + CW + 1 > SW0) ? FRAC_BITS + CW + 1 : SW0;
    localparam logic [SW-1:0] FOUR = {{(SW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_SQX   = 5'b00010,
        E_SQY   = 5'b00100,
        E_CROSS = 5'b01000,
        E_UPD   = 5'b10000
    } eng_state_t;

    eng_state_t state_reg, state_next;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, xy_reg;
    logic [LIMIT_W-1:0]   cnt_reg;

    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [SW-1:0]        mag;
    logic signed [SW-1:0] xx_w, yy_w, xy_w, diff, diff_sh, xy_sh;
    logic                 escape;
    logic                 at_limit;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            E_SQX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            E_SQY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign xx_w    = SW'(xx_reg);
    assign yy_w    = SW'(yy_reg);
    assign xy_w    = SW'(xy_reg);
    assign mag     = SW'($unsigned(xx_reg)) + SW'($unsigned(yy_reg));
    assign escape  = !(mag < FOUR);
    assign diff    = xx_w - yy_w;
    assign diff_sh = diff >>> FRAC_BITS;
    assign xy_sh   = xy_w >>> (FRAC_BITS - 1);
    assign at_limit = (cnt_reg == ctl.limit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:  if (ctl.start) state_next = E_SQX;
            E_SQX:   state_next = at_limit ? E_IDLE : E_SQY;
            E_SQY:   state_next = E_CROSS;
            E_CROSS: state_next = escape ? E_IDLE : E_UPD;
            E_UPD:   state_next = E_SQX;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == E_IDLE && ctl.start)
                cnt_reg <= '0;
            else if (state_reg == E_UPD)
                cnt_reg <= cnt_reg + LIMIT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            E_IDLE:
            begin
                if (ctl.start)
                begin
                    x_reg <= '0;
                    y_reg <= '0;
                end
            end
            E_SQX:   xx_reg <= mul_p;
            E_SQY:   yy_reg <= mul_p;
            E_CROSS: xy_reg <= mul_p;
            E_UPD:
            begin
                x_reg <= diff_sh[CW-1:0] + cx;
                y_reg <= xy_sh[CW-1:0] + cy;
            end
            default: ;
        endcase
    end

    assign status.done  = (state_reg == E_SQX && at_limit) ||
                          (state_reg == E_CROSS && escape);
    assign status.count = cnt_reg;

endmodule

// File: src/mandelbrot_escape_pixel_unit.sv
// Channel | Dir | Signals                  | Payload
// s       | in  | s_tvalid/tready/tdata    | pixel_column, pixel_row
// m       | out | m_tvalid/tready/tdata/tuser | count, red, green, blue; inside_set
// cfg     | in  | cfg_we/cfg_index/cfg_data | left, top, step, limit registers
//
// A pixel ends when it escapes or runs to the iteration limit; each iteration
// makes three passes through the one shared multiplier plus an update step.
// Reset loads the default view and limit and empties the output register.
// A finished result waits in the output register; the next pixel is taken
// meanwhile and holds in the engine if the result is still not taken.
module mandelbrot_escape_pixel_unit
    import mep_pkg::*;
#(
    parameter int FRAC_BITS   = 28,
    parameter int COORD_WIDTH = 32,
    parameter int MAX_DIM     = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [((2 * $clog2(MAX_DIM) + 7) / 8) * 8 - 1:0] s_tdata, // column, row
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,  // iteration_count, red, green, blue
    output logic                   m_tuser,  // inside_set
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int MW    = (DIM_W + STEP_W > CW) ? DIM_W + STEP_W : CW;
    localparam int EW    = (EDGE_W > CW) ? EDGE_W : CW;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAPX = 5'b00010,
        ST_MAPY = 5'b00100,
        ST_RUN  = 5'b01000,
        ST_HOLD = 5'b10000
    } top_state_t;

    top_state_t state_reg, state_next;

    logic signed [EDGE_W-1:0] left_reg, top_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    logic [DIM_W-1:0]     col_reg, row_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic                 m_tuser_reg;

    logic [DIM_W-1:0]     map_sel;
    logic [MW-1:0]        map_p;
    logic signed [EW-1:0] left_ext, top_ext;
    logic                 can_load, load;
    logic                 in_set;
    logic [COLOR_W-1:0]   red, green, blue;

    mep_ctl_t    ctl;
    mep_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= RST_LEFT;
            top_reg   <= RST_TOP;
            step_reg  <= RST_STEP;
            limit_reg <= RST_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT:  left_reg  <= cfg_data[EDGE_W-1:0];
                REG_TOP:   top_reg   <= cfg_data[EDGE_W-1:0];
                REG_STEP:  step_reg  <= cfg_data[STEP_W-1:0];
                REG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel to point, one mapping multiplier used for column then row
    assign map_sel  = (state_reg == ST_MAPX) ? col_reg : row_reg;
    assign map_p    = MW'(map_sel) * MW'(step_reg);
    assign left_ext = EW'(left_reg);
    assign top_ext  = EW'(top_reg);

    assign can_load = !m_tvalid_reg || m_tready;
    assign load     = ((state_reg == ST_RUN && status.done) || state_reg == ST_HOLD)
                      && can_load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MAPX;
            ST_MAPX: state_next = ST_MAPY;
            ST_MAPY: state_next = ST_RUN;
            ST_RUN:
            begin
                if (status.done)
                    state_next = can_load ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (can_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            col_reg <= s_tdata[DIM_W-1:0];
            row_reg <= s_tdata[2*DIM_W-1:DIM_W];
        end
        if (state_reg == ST_MAPX)
            cx_reg <= left_ext[CW-1:0] + map_p[CW-1:0];
        if (state_reg == ST_MAPY)
            cy_reg <= top_ext[CW-1:0] - map_p[CW-1:0];
        if (load)
        begin
            m_tdata_reg <= {blue, green, red, status.count};
            m_tuser_reg <= in_set;
        end
    end

    assign in_set = (status.count == limit_reg);
    assign red    = in_set ? '0 : status.count[7:0];
    assign green  = in_set ? '0 : status.count[15:8];
    assign blue   = in_set ? '0 : status.count[23:16];

    assign ctl.start = (state_reg == ST_MAPY);
    assign ctl.limit = limit_reg;

    mep_iter #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cx     (cx_reg),
        .cy     (cy_reg),
        .status (status)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
